### hw/rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Types, constants and microcode for the motor feedback multi-turn decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

  // Encoder counts per revolution; must be a power of two.
  localparam int unsigned ENCODER_COUNTS = 8192;
  localparam int unsigned ENC_SHIFT      = $clog2(ENCODER_COUNTS);
  localparam int unsigned ENC_HALF       = ENCODER_COUNTS / 2;
  localparam logic signed [17:0] ENC_HALF_S = 18'(ENC_HALF);

  localparam logic [10:0] FIRST_ID  = 11'd517;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [15:0] ALPHA_RST = 16'd58982;

  // Shared multiply-accumulate unit widths
  localparam int unsigned OPND_W = 33;
  localparam int unsigned ACC_W  = 66;

  // 2*pi/60 in Q0.32, and 2*pi in Q.32 split at bit 32
  localparam logic signed [OPND_W-1:0] RPM_TO_RADS_Q32 = 33'sd449767923;
  localparam logic signed [OPND_W-1:0] TWO_PI_LO       = 33'sd1216271633;
  localparam logic signed [OPND_W-1:0] TWO_PI_HI       = 33'sd6;
  localparam logic signed [OPND_W-1:0] OPND_ONE        = 33'sd1;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd21;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_REVERSE  = 3'd0,
    CFG_ANGLE_OFFSET = 3'd1,
    CFG_FILTER_ALPHA = 3'd2,
    CFG_TORQUE_SCALE = 3'd3,
    CFG_SLOT_MASK    = 3'd4
  } mfd_cfg_idx_t;

  typedef struct packed {
    logic [10:0]        frame_id;
    logic               is_extended;
    logic signed [15:0] encoder_raw;
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
  } mfd_in_t;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot_index;
    logic signed [47:0] angle_out;
    logic signed [31:0] speed_out;
    logic signed [31:0] torque_out;
    logic signed [15:0] turn_count;
  } mfd_out_t;

  typedef struct packed {
    logic signed [31:0] filt_s;
    logic signed [31:0] filt_t;
    logic signed [47:0] filt_a;
  } mfd_filt_t;

  typedef struct packed {
    logic signed [14:0] last_enc;
    logic signed [15:0] turns;
    mfd_filt_t          filt;
  } mfd_slot_t;

  // Operands handed to the shared unit for the frame in flight
  typedef struct packed {
    logic signed [16:0] spd;
    logic signed [16:0] cur;
    logic signed [15:0] enc;
    logic signed [15:0] turns;
    logic signed [31:0] offset;
    logic [15:0]        alpha;
    logic [31:0]        tscale;
    mfd_filt_t          prev;
  } mfd_ctx_t;

  typedef enum logic [2:0] {
    OP_MAC,
    OP_SPD_FRESH,
    OP_TRQ_FRESH,
    OP_SPD_WB,
    OP_TRQ_WB,
    OP_ENC_DIV,
    OP_ANG_FRESH,
    OP_ANG_WB
  } mfd_op_t;

  typedef enum logic [3:0] {
    A_SPD,
    A_CUR,
    A_ENC,
    A_TURNS,
    A_OFFSET,
    A_PREV_S,
    A_PREV_T,
    A_FRESH_S,
    A_FRESH_T,
    A_PREV_A_HI,
    A_PREV_A_LO,
    A_FRESH_A_HI,
    A_FRESH_A_LO
  } mfd_asel_t;

  typedef enum logic [2:0] {
    B_RPM,
    B_TSCALE,
    B_ALPHA,
    B_BETA,
    B_TP_LO,
    B_TP_HI,
    B_ONE
  } mfd_bsel_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_32
  } mfd_sh_t;

  typedef struct packed {
    mfd_op_t   op;
    logic      first;
    mfd_asel_t a_sel;
    mfd_bsel_t b_sel;
    mfd_sh_t   sh;
  } mfd_ucode_t;

  typedef struct packed {
    logic       run;
    mfd_ucode_t uc;
  } mfd_ctl_t;

  typedef struct packed {
    logic take;
    logic load;
    logic busy;
    logic out_valid;
    logic retire;
  } mfd_stat_t;

  function automatic mfd_ucode_t uc_mac(input logic first, input mfd_asel_t a,
                                        input mfd_bsel_t b, input mfd_sh_t sh);
    return '{op: OP_MAC, first: first, a_sel: a, b_sel: b, sh: sh};
  endfunction

  function automatic mfd_ucode_t uc_post(input mfd_op_t op);
    return '{op: op, first: 1'b0, a_sel: A_SPD, b_sel: B_RPM, sh: SH_0};
  endfunction

  // One entry per cycle of the shared unit
  function automatic mfd_ucode_t step_ucode(input logic [STEP_W-1:0] step);
    mfd_ucode_t u;
    u = uc_post(OP_ANG_WB);
    case (step)
      5'd0:  u = uc_mac(1'b1, A_SPD,        B_RPM,    SH_0);
      5'd1:  u = uc_post(OP_SPD_FRESH);
      5'd2:  u = uc_mac(1'b1, A_CUR,        B_TSCALE, SH_0);
      5'd3:  u = uc_post(OP_TRQ_FRESH);
      5'd4:  u = uc_mac(1'b1, A_PREV_S,     B_ALPHA,  SH_0);
      5'd5:  u = uc_mac(1'b0, A_FRESH_S,    B_BETA,   SH_0);
      5'd6:  u = uc_post(OP_SPD_WB);
      5'd7:  u = uc_mac(1'b1, A_PREV_T,     B_ALPHA,  SH_0);
      5'd8:  u = uc_mac(1'b0, A_FRESH_T,    B_BETA,   SH_0);
      5'd9:  u = uc_post(OP_TRQ_WB);
      5'd10: u = uc_mac(1'b1, A_ENC,        B_TP_LO,  SH_0);
      5'd11: u = uc_mac(1'b0, A_ENC,        B_TP_HI,  SH_32);
      5'd12: u = uc_post(OP_ENC_DIV);
      5'd13: u = uc_mac(1'b0, A_TURNS,      B_TP_LO,  SH_0);
      5'd14: u = uc_mac(1'b0, A_TURNS,      B_TP_HI,  SH_32);
      5'd15: u = uc_mac(1'b0, A_OFFSET,     B_ONE,    SH_16);
      5'd16: u = uc_post(OP_ANG_FRESH);
      5'd17: u = uc_mac(1'b1, A_PREV_A_HI,  B_ALPHA,  SH_16);
      5'd18: u = uc_mac(1'b0, A_PREV_A_LO,  B_ALPHA,  SH_0);
      5'd19: u = uc_mac(1'b0, A_FRESH_A_HI, B_BETA,   SH_16);
      5'd20: u = uc_mac(1'b0, A_FRESH_A_LO, B_BETA,   SH_0);
      5'd21: u = uc_post(OP_ANG_WB);
      default: u = uc_post(OP_ANG_WB);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mfd_slot_regs.sv
// ----------------------------------------------------------------------------
// mfd_slot_regs
// Per-slot state: last encoder count, turn counter and filter states.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_slot_regs import mfd_pkg::*; #(
  parameter int unsigned SLOTS = 7,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  output mfd_slot_t        rd_data,
  input  logic             wr_en,
  input  mfd_slot_t        wr_data
);

  mfd_slot_t slot_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else if (wr_en) begin
      slot_r[idx] <= wr_data;
    end
  end

  assign rd_data = slot_r[idx];

endmodule

`default_nettype wire

### hw/rtl/mfd_alu.sv
// ----------------------------------------------------------------------------
// mfd_alu
// Shared 33x33 multiply-accumulate unit with rounding and saturation steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_alu import mfd_pkg::*; (
  input  logic      clk,
  input  mfd_ctl_t  ctl,
  input  mfd_ctx_t  ctx,
  output mfd_filt_t res
);

  localparam logic signed [ACC_W-1:0] HALF16  = ACC_W'(1) << 15;
  localparam logic signed [ACC_W-1:0] HALF8   = ACC_W'(1) << 7;
  localparam logic signed [ACC_W-1:0] ENC_RND = ACC_W'(ENCODER_COUNTS - 1);
  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'h7fff_ffff);
  localparam logic signed [ACC_W-1:0] S32_MIN = ~S32_MAX;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [31:0]       fresh_s_r, fresh_t_r;
  logic signed [47:0]       fresh_a_r;
  mfd_filt_t                res_r;

  logic signed [OPND_W-1:0] opa, opb;
  logic signed [ACC_W-1:0]  prod, prod_sh, acc_base;
  logic signed [ACC_W-1:0]  rnd16, rnd8, trunc_div;
  logic signed [31:0]       trq_sat;
  logic [16:0]              beta;

  assign beta = 17'h10000 - {1'b0, ctx.alpha};

  always_comb begin
    case (ctl.uc.a_sel)
      A_SPD:        opa = 33'(ctx.spd);
      A_CUR:        opa = 33'(ctx.cur);
      A_ENC:        opa = 33'(ctx.enc);
      A_TURNS:      opa = 33'(ctx.turns);
      A_OFFSET:     opa = 33'(ctx.offset);
      A_PREV_S:     opa = 33'(ctx.prev.filt_s);
      A_PREV_T:     opa = 33'(ctx.prev.filt_t);
      A_FRESH_S:    opa = 33'(fresh_s_r);
      A_FRESH_T:    opa = 33'(fresh_t_r);
      A_PREV_A_HI:  opa = 33'($signed(ctx.prev.filt_a[47:16]));
      A_PREV_A_LO:  opa = {17'b0, ctx.prev.filt_a[15:0]};
      A_FRESH_A_HI: opa = 33'($signed(fresh_a_r[47:16]));
      A_FRESH_A_LO: opa = {17'b0, fresh_a_r[15:0]};
      default:      opa = '0;
    endcase
  end

  always_comb begin
    case (ctl.uc.b_sel)
      B_RPM:    opb = RPM_TO_RADS_Q32;
      B_TSCALE: opb = {1'b0, ctx.tscale};
      B_ALPHA:  opb = {17'b0, ctx.alpha};
      B_BETA:   opb = {16'b0, beta};
      B_TP_LO:  opb = TWO_PI_LO;
      B_TP_HI:  opb = TWO_PI_HI;
      B_ONE:    opb = OPND_ONE;
      default:  opb = '0;
    endcase
  end

  assign prod = opa * opb;

  always_comb begin
    case (ctl.uc.sh)
      SH_0:    prod_sh = prod;
      SH_16:   prod_sh = prod <<< 16;
      SH_32:   prod_sh = prod <<< 32;
      default: prod_sh = prod;
    endcase
  end

  assign acc_base = ctl.uc.first ? '0 : acc_r;

  // round half up: add half an LSB, then floor
  assign rnd16 = (acc_r + HALF16) >>> 16;
  assign rnd8  = (acc_r + HALF8) >>> 8;
  // divide by the encoder count, truncating toward zero
  assign trunc_div = (acc_r[ACC_W-1] ? acc_r + ENC_RND : acc_r) >>> ENC_SHIFT;

  always_comb begin
    if (rnd8 > S32_MAX) begin
      trq_sat = S32_MAX[31:0];
    end else if (rnd8 < S32_MIN) begin
      trq_sat = S32_MIN[31:0];
    end else begin
      trq_sat = rnd8[31:0];
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    case (ctl.uc.op)
      OP_MAC:     acc_nxt = acc_base + prod_sh;
      OP_ENC_DIV: acc_nxt = trunc_div;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      acc_r <= acc_nxt;
      case (ctl.uc.op)
        OP_SPD_FRESH: fresh_s_r    <= rnd16[31:0];
        OP_TRQ_FRESH: fresh_t_r    <= trq_sat;
        OP_SPD_WB:    res_r.filt_s <= rnd16[31:0];
        OP_TRQ_WB:    res_r.filt_t <= rnd16[31:0];
        OP_ANG_FRESH: fresh_a_r    <= rnd16[47:0];
        OP_ANG_WB:    res_r.filt_a <= rnd16[47:0];
        default: ;
      endcase
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

### hw/rtl/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl
// Frame sequencer: accept, slot load, microcode steps, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_ctrl import mfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      hit,
  input  logic      out_stall,
  output mfd_ctl_t  ctl,
  output mfd_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_OUT  = 4'b1000
  } mfd_state_t;

  mfd_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        // rejected frames skip straight to the result
        if (in_valid) begin
          state_nxt = hit ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_RUN;
        step_nxt  = '0;
      end
      ST_RUN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign ctl.run = (state_r == ST_RUN);
  assign ctl.uc  = step_ucode(step_r);

  assign stat.take      = (state_r == ST_IDLE) && in_valid;
  assign stat.load      = (state_r == ST_LOAD);
  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.out_valid = (state_r == ST_OUT);
  assign stat.retire    = (state_r == ST_OUT) && !out_stall;

endmodule

`default_nettype wire

### hw/rtl/motor_feedback_multiturn_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder
// Decodes motor feedback frames into filtered speed, torque and multi-turn
// angle per motor slot.
// ----------------------------------------------------------------------------
// One frame at a time. A rejected frame (extended, identifier out of range or
// slot disabled) gives an all-zero result in the cycle after it is taken, and
// the next frame can be taken once that result has been taken. An accepted
// frame reads its slot in the load state, then runs 22 microcode steps on the
// single shared 33x33 multiply-accumulate unit; its result shows after the
// last step, and the next frame can be taken once the result beat has been
// taken. in_stall is high from the cycle after the taken beat until the
// result is taken. Slot state resets to zero with rst_n; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedback_multiturn_decoder import mfd_pkg::*; #(
  parameter int unsigned MOTOR_SLOTS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mfd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mfd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  // configuration
  logic               dir_rev_r;
  logic signed [31:0] offset_r;
  logic [15:0]        alpha_r;
  logic [31:0]        tscale_r;
  logic [6:0]         mask_r;

  // frame in flight
  logic               hit_r;
  logic [SLOT_W-1:0]  slot_r;
  logic signed [15:0] enc_r;
  logic signed [16:0] spd_r, cur_r;
  logic signed [15:0] turns_r, turns_nxt;

  logic [11:0]        id_off;
  logic [7:0]         mask_ext;
  logic               hit;
  logic signed [15:0] enc_adj;
  logic signed [16:0] spd_ext, cur_ext, spd_adj, cur_adj;
  logic signed [17:0] diff;

  mfd_ctl_t  ctl;
  mfd_stat_t stat;
  mfd_ctx_t  ctx;
  mfd_filt_t filt;
  mfd_slot_t slot_rd, slot_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_rev_r <= 1'b0;
      offset_r  <= '0;
      alpha_r   <= ALPHA_RST;
      tscale_r  <= '0;
      mask_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIR_REVERSE:  dir_rev_r <= cfg_wdata[0];
        CFG_ANGLE_OFFSET: offset_r  <= cfg_wdata;
        CFG_FILTER_ALPHA: alpha_r   <= cfg_wdata[15:0];
        CFG_TORQUE_SCALE: tscale_r  <= cfg_wdata;
        CFG_SLOT_MASK:    mask_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // frame filter
  assign id_off   = {1'b0, in_data.frame_id} - {1'b0, FIRST_ID};
  assign mask_ext = {1'b0, mask_r};
  assign hit = !in_data.is_extended && (in_data.frame_id >= FIRST_ID) &&
               (id_off < 12'(MOTOR_SLOTS)) && mask_ext[id_off[SLOT_W-1:0]];

  // direction; encoder negation wraps in 16 bits
  assign enc_adj = dir_rev_r ? 16'(-in_data.encoder_raw) : in_data.encoder_raw;
  assign spd_ext = 17'(in_data.speed_raw);
  assign cur_ext = 17'(in_data.current_raw);
  assign spd_adj = dir_rev_r ? -spd_ext : spd_ext;
  assign cur_adj = dir_rev_r ? -cur_ext : cur_ext;

  always_ff @(posedge clk) begin
    if (stat.take) begin
      hit_r  <= hit;
      slot_r <= id_off[SLOT_W-1:0];
      enc_r  <= enc_adj;
      spd_r  <= spd_adj;
      cur_r  <= cur_adj;
    end
    if (stat.load) begin
      turns_r <= turns_nxt;
    end
  end

  // turn counting: a jump over half a revolution wraps, counter saturates
  assign diff = 18'(enc_r) - 18'(slot_rd.last_enc);

  always_comb begin
    turns_nxt = slot_rd.turns;
    if (diff > ENC_HALF_S) begin
      if (slot_rd.turns != 16'sh8000) begin
        turns_nxt = slot_rd.turns - 16'sd1;
      end
    end else if (diff < -ENC_HALF_S) begin
      if (slot_rd.turns != 16'sh7fff) begin
        turns_nxt = slot_rd.turns + 16'sd1;
      end
    end
  end

  mfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .hit       (hit),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  assign slot_wr.last_enc = enc_r[14:0];
  assign slot_wr.turns    = turns_r;
  assign slot_wr.filt     = filt;

  mfd_slot_regs #(
    .SLOTS (MOTOR_SLOTS),
    .IDX_W (IDX_W)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     (slot_r[IDX_W-1:0]),
    .rd_data (slot_rd),
    .wr_en   (stat.retire && hit_r),
    .wr_data (slot_wr)
  );

  assign ctx.spd    = spd_r;
  assign ctx.cur    = cur_r;
  assign ctx.enc    = enc_r;
  assign ctx.turns  = turns_r;
  assign ctx.offset = offset_r;
  assign ctx.alpha  = alpha_r;
  assign ctx.tscale = tscale_r;
  assign ctx.prev   = slot_rd.filt;

  mfd_alu u_alu (
    .clk (clk),
    .ctl (ctl),
    .ctx (ctx),
    .res (filt)
  );

  assign in_stall  = stat.busy;
  assign out_valid = stat.out_valid;

  always_comb begin
    out_data = '0;
    if (hit_r) begin
      out_data.accepted   = 1'b1;
      out_data.slot_index = slot_r;
      out_data.angle_out  = filt.filt_a;
      out_data.speed_out  = filt.filt_s;
      out_data.torque_out = filt.filt_t;
      out_data.turn_count = turns_r;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mfd_checker.sv
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks for the motor feedback multi-turn decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_checker import mfd_pkg::*; #(
  parameter int unsigned MOTOR_SLOTS = 7
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input mfd_out_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a beat was taken");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      (out_data.slot_index == '0) && (out_data.angle_out == '0) &&
      (out_data.speed_out == '0) && (out_data.torque_out == '0) &&
      (out_data.turn_count == '0))
    else $error("rejected frame result not all zero");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> (out_data.slot_index < SLOT_W'(MOTOR_SLOTS)))
    else $error("accepted frame reports slot out of range");

endmodule

bind motor_feedback_multiturn_decoder mfd_checker #(
  .MOTOR_SLOTS (MOTOR_SLOTS)
) u_mfd_checker (.*);

`default_nettype wire
